### rtl/core/ndgt_pkg.sv
// ============================================================================
// ndgt_pkg : shared types and constants for the named directed graph table
// command codes, status codes, queue entry and back-end state encoding
// ============================================================================
package ndgt_pkg;

    localparam int MaxNodes  = 32;
    localparam int SlotW     = $clog2(MaxNodes);
    localparam int CountW    = $clog2(MaxNodes + 1);
    localparam int KeyW      = 64;
    localparam int SlotOutW  = 5;

    typedef enum logic [2:0] {
        FN_ADD_NODE = 3'd0,
        FN_DEL_NODE = 3'd1,
        FN_ADD_EDGE = 3'd2,
        FN_DEL_EDGE = 3'd3,
        FN_LIST_OUT = 3'd4,
        FN_LIST_IN  = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_FULL     = 3'd1,
        ST_PRESENT  = 3'd2,
        ST_MISSING  = 3'd3,
        ST_NEIGHBOR = 3'd4,
        ST_NONE     = 3'd5
    } t_status;

    // one classified command between front and back
    typedef struct packed {
        logic [2:0]      func;
        logic [KeyW-1:0] key_a;
        logic [KeyW-1:0] key_b;
    } t_cmd;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_SEARCH,
        BS_DECIDE,
        BS_SHIFT,
        BS_COLS,
        BS_LIST,
        BS_LIST_RD,
        BS_EMIT,
        BS_WAIT
    } t_bstate;

endpackage

### rtl/core/ndgt_front.sv
// ============================================================================
// ndgt_front : command intake
// accepts command beats, drops unused codes, queues the rest in a small fifo
// ============================================================================
module ndgt_front
    import ndgt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_cmd       i_cmd,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cmd       o_cmd
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop, w_keep;

    assign o_ready = (r_cnt != 2'd2);
    assign w_keep  = (i_cmd.func <= FN_LIST_IN);
    assign w_push  = i_valid && o_ready && w_keep;
    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

### rtl/core/ndgt_back.sv
// ============================================================================
// ndgt_back : command execution
// name search, table compaction, edge update and neighbor listing
// ============================================================================
module ndgt_back
    import ndgt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_cmd                i_cmd,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_status,
    output logic [KeyW-1:0]     o_key,
    output logic [SlotOutW-1:0] o_slot,
    output logic                o_last
);

    logic [KeyW-1:0]     r_names [MaxNodes];
    logic [MaxNodes-1:0] r_adj   [MaxNodes];
    logic [CountW-1:0]   r_count;

    t_bstate r_st, n_st;
    t_cmd    r_cmd;
    logic [CountW-1:0] r_i;
    logic [SlotW-1:0]  r_a, r_b;
    logic              r_fa, r_fb;
    logic [2:0]        r_pst;
    logic              r_hit_pend;
    logic [SlotW-1:0]  r_hit_slot;
    logic              r_ov;
    logic [2:0]        r_os;
    logic [KeyW-1:0]   r_ok;
    logic [SlotOutW-1:0] r_osl;
    logic              r_ol;

    logic [SlotW-1:0] w_i;
    logic             w_end;
    logic             w_hit;
    logic             w_out_free;
    logic             w_put;

    assign w_i        = r_i[SlotW-1:0];
    assign w_end      = (r_i >= r_count);
    assign w_out_free = !r_ov || i_ready;
    assign w_put      = w_out_free && ((r_st == BS_WAIT) ||
                        ((r_st == BS_EMIT) && (w_end || (w_hit && r_hit_pend))));
    assign o_ready    = (r_st == BS_IDLE);
    assign o_valid    = r_ov;
    assign o_status   = r_os;
    assign o_key      = r_ok;
    assign o_slot     = r_osl;
    assign o_last     = r_ol;

    always_comb begin
        if (r_cmd.func == FN_LIST_OUT) w_hit = r_adj[r_a][w_i];
        else                           w_hit = r_adj[w_i][r_a];
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            BS_IDLE:    if (i_valid) n_st = BS_SEARCH;
            BS_SEARCH:  if (w_end) n_st = BS_DECIDE;
            BS_DECIDE: begin
                case (r_cmd.func)
                    FN_DEL_NODE:             n_st = r_fa ? BS_SHIFT : BS_WAIT;
                    FN_LIST_OUT, FN_LIST_IN: n_st = r_fa ? BS_LIST : BS_WAIT;
                    default:                 n_st = BS_WAIT;
                endcase
            end
            BS_SHIFT:   if (r_i + 1'b1 >= r_count) n_st = BS_COLS;
            BS_COLS:    if (w_end) n_st = BS_WAIT;
            BS_LIST:    n_st = BS_LIST_RD;
            BS_LIST_RD: n_st = BS_EMIT;
            BS_EMIT:    if (w_out_free && w_end) n_st = BS_IDLE;
            BS_WAIT:    if (w_out_free) n_st = BS_IDLE;
            default:    n_st = BS_IDLE;
        endcase
    end

    task automatic put(input logic [2:0] s, input logic [KeyW-1:0] k,
                       input logic [SlotOutW-1:0] sl, input logic l);
        r_os  <= s;
        r_ok  <= k;
        r_osl <= sl;
        r_ol  <= l;
    endtask

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= BS_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
            for (int k = 0; k < MaxNodes; k++) r_adj[k] <= '0;
        end else begin
            r_st <= n_st;
            r_ov <= w_put || (r_ov && !i_ready);
            case (r_st)
                BS_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                        r_i   <= '0;
                        r_fa  <= 1'b0;
                        r_fb  <= 1'b0;
                    end
                end
                BS_SEARCH: begin
                    // one table entry per cycle, first match wins
                    if (!w_end) begin
                        if (!r_fa && r_names[w_i] == r_cmd.key_a) begin
                            r_fa <= 1'b1;
                            r_a  <= w_i;
                        end
                        if (!r_fb && r_names[w_i] == r_cmd.key_b) begin
                            r_fb <= 1'b1;
                            r_b  <= w_i;
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                BS_DECIDE: begin
                    r_i <= {1'b0, r_a};
                    case (r_cmd.func)
                        FN_ADD_NODE: begin
                            if (r_count == CountW'(MaxNodes)) begin
                                r_pst <= ST_FULL;
                            end else if (r_fa) begin
                                r_pst <= ST_PRESENT;
                            end else begin
                                r_names[w_i] <= r_cmd.key_a;
                                r_adj[w_i]   <= '0;
                                r_count      <= r_count + 1'b1;
                                r_pst        <= ST_DONE;
                            end
                        end
                        FN_DEL_NODE: begin
                            r_pst <= r_fa ? ST_DONE : ST_MISSING;
                        end
                        FN_ADD_EDGE, FN_DEL_EDGE: begin
                            if (r_fa && r_fb) begin
                                r_adj[r_a][r_b] <= (r_cmd.func == FN_ADD_EDGE);
                                r_pst <= ST_DONE;
                            end else begin
                                r_pst <= ST_MISSING;
                            end
                        end
                        default: begin
                            r_pst <= r_fa ? ST_NONE : ST_MISSING;
                        end
                    endcase
                end
                BS_SHIFT: begin
                    // move later rows down one slot, clear the top row's edges
                    if (r_i + 1'b1 < r_count) begin
                        r_names[w_i] <= r_names[w_i + 1'b1];
                        r_adj[w_i]   <= r_adj[w_i + 1'b1];
                        r_i          <= r_i + 1'b1;
                    end else begin
                        r_adj[w_i] <= '0;
                        r_i        <= '0;
                        r_count    <= r_count - 1'b1;
                    end
                end
                BS_COLS: begin
                    // close the column gap one row per cycle
                    if (!w_end) begin
                        for (int j = 0; j < MaxNodes; j++) begin
                            if (j >= r_a) begin
                                r_adj[w_i][j] <= (j + 1 < MaxNodes &&
                                    j + 1 < r_count + 1) ?
                                    r_adj[w_i][(j + 1) % MaxNodes] : 1'b0;
                            end
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                BS_LIST: begin
                    r_i        <= '0;
                    r_hit_pend <= 1'b0;
                end
                BS_LIST_RD: ;
                BS_EMIT: begin
                    // scan one slot per cycle while the output is free; hold one found hit until the next
                    // is known so that the final one carries last
                    if (w_out_free) begin
                        if (!w_end) begin
                            r_i <= r_i + 1'b1;
                            if (w_hit) begin
                                if (r_hit_pend)
                                    put(ST_NEIGHBOR, r_names[r_hit_slot],
                                        SlotOutW'(r_hit_slot), 1'b0);
                                r_hit_pend <= 1'b1;
                                r_hit_slot <= w_i;
                            end
                        end else begin
                            if (r_hit_pend)
                                put(ST_NEIGHBOR, r_names[r_hit_slot],
                                    SlotOutW'(r_hit_slot), 1'b1);
                            else
                                put(ST_NONE, '0, '0, 1'b1);
                        end
                    end
                end
                BS_WAIT: begin
                    if (w_out_free) begin
                        put(r_pst, '0, '0, 1'b1);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

### rtl/core/named_directed_graph_table.sv
// ============================================================================
// named_directed_graph_table : directed graph of named nodes
// packed name table plus bit adjacency matrix, commands in, results out
// ============================================================================
// channel   dir  fields (lsb first)
// s_axis    in   tdata: func[2:0] key_a[66:3] key_b[130:67], pad to 136
// m_axis    out  tdata: status[2:0] neighbour_key[66:3] neighbour_slot[71:67]
//                tlast: last
//
// a single-result command is taken from the queue, searched against every stored
// name, decided, then issued; a removal adds a row shift from the removed slot
// up and a column close over every remaining row; a list adds setup and then a
// scan of every slot, one slot per cycle while the output is not stalled
// reset clears count and matrix at once; names are undefined until written
// a two-entry queue lets intake continue while the back end is busy; a held
// result beat stalls the back end's issue and list scan until m_axis_tready takes it
module named_directed_graph_table
    import ndgt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,   // func, key_a, key_b
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,   // status, neighbour_key, neighbour_slot
    output logic         m_axis_tlast    // last
);

    t_cmd w_in_cmd, w_q_cmd;
    logic w_q_valid, w_q_ready;
    logic [2:0] w_status;
    logic [KeyW-1:0] w_key;
    logic [SlotOutW-1:0] w_slot;

    assign w_in_cmd.func  = s_axis_tdata[2:0];
    assign w_in_cmd.key_a = s_axis_tdata[66:3];
    assign w_in_cmd.key_b = s_axis_tdata[130:67];

    ndgt_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(w_in_cmd),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_cmd(w_q_cmd)
    );

    ndgt_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_cmd(w_q_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(w_status), .o_key(w_key), .o_slot(w_slot), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {w_slot, w_key, w_status};

endmodule

### rtl/core/ndgt_checker.sv
// ============================================================================
// ndgt_checker : port-level checks for the graph table
// result stream behavior seen at the top level ports
// ============================================================================
module ndgt_checker
    import ndgt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_nb_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != ST_NEIGHBOR |-> m_axis_tlast)
        else $error("single result without last");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != ST_NEIGHBOR |-> m_axis_tdata[71:3] == '0)
        else $error("non-neighbor result carries data");

endmodule

bind named_directed_graph_table ndgt_checker u_chk (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);
